### sv/ean8_pkg.sv
`default_nettype none

package ean8_pkg;

	localparam int CFG_W = 11;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CFG_IMAGE_WIDTH = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd1024;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_MEASURE,
		PH_SAMPLE,
		PH_DONE
	} phase_t;

	// one completed 7-module group headed for the decode stage
	typedef struct packed {
		logic [6:0] bits;
		logic [2:0] position;
	} group_t;

	typedef logic [6:0] code_tab_t [10];

	localparam code_tab_t L_CODES = '{
		7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23,
		7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
	};
	localparam code_tab_t R_CODES = '{
		7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C,
		7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
	};

	// returns {hit, digit}; digit is 0 on a miss
	function automatic logic [4:0] match_code(input logic [6:0] code, input logic right_half);
		logic [3:0] d;
		logic hit;
		d = 4'd0;
		hit = 1'b0;
		for (int k = 9; k >= 0; k--) begin
			if ((right_half ? R_CODES[k] : L_CODES[k]) == code) begin
				d = 4'(k);
				hit = 1'b1;
			end
		end
		return {hit, d};
	endfunction

endpackage

`default_nettype wire

### sv/ean8_front.sv
`default_nettype none

module ean8_front import ean8_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CFG_W-1:0] image_width,
	input  wire logic [CFG_W-1:0] image_height,
	input  wire logic             pixel,
	input  wire logic             pixel_valid,
	output logic                  pixel_stall,
	input  wire logic             queue_full,
	output logic                  push,
	output group_t                push_group
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HW = RW + 1;
	localparam int NW = CW + 7;
	localparam int CMPW_W = (WW > CFG_W) ? WW : CFG_W;
	localparam int CMPW_H = (HW > CFG_W) ? HW : CFG_W;

	phase_t phase_q, phase_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [CW-1:0] left_q, left_d;
	logic [WW-1:0] mw_q, mw_d;
	logic [NW-1:0] next_q, next_d;
	logic [6:0] bits_q, bits_d;
	logic [2:0] held_q, held_d;
	logic [3:0] done_q, done_d;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic accept;
	logic [WW-1:0] col_inc;
	logic [HW-1:0] row_inc;
	logic [WW-1:0] col_plus_left;
	logic [NW-1:0] mw_x;
	logic sample_hit, drop, take, group_full;
	logic [6:0] bits_shift;

	always_comb begin
		if (image_width == '0) begin
			w_eff = WW'(1);
		end else if (CMPW_W'(image_width) > CMPW_W'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width);
		end
		if (image_height == '0) begin
			h_eff = HW'(1);
		end else if (CMPW_H'(image_height) > CMPW_H'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(image_height);
		end
	end

	assign pixel_stall = queue_full;
	assign accept = pixel_valid && !queue_full;

	assign col_inc = {1'b0, col_q} + WW'(1);
	assign row_inc = {1'b0, row_q} + HW'(1);
	assign col_plus_left = {1'b0, col_q} + {1'b0, left_q};
	assign mw_x = NW'(mw_q);
	assign bits_shift = {bits_q[5:0], pixel};

	assign sample_hit = (phase_q == PH_SAMPLE) && (NW'(col_q) == next_q);
	assign drop = sample_hit && (done_q[3] || done_q[2]) && (col_plus_left > w_eff);
	assign take = sample_hit && !drop;
	assign group_full = take && (held_q == 3'd6);

	// next state
	always_comb begin
		phase_d = phase_q;
		col_d = col_q;
		row_d = row_q;
		left_d = left_q;
		mw_d = mw_q;
		next_d = next_q;
		bits_d = bits_q;
		held_d = held_q;
		done_d = done_q;
		if (accept) begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (pixel) begin
						left_d = col_q;
						mw_d = WW'(1);
						phase_d = PH_MEASURE;
					end
				end
				PH_MEASURE: begin
					if (pixel) begin
						mw_d = mw_q + WW'(1);
					end else begin
						phase_d = PH_SAMPLE;
						next_d = NW'(left_q) + (mw_x << 1) + mw_x;
					end
				end
				PH_SAMPLE: begin
					if (drop) begin
						phase_d = PH_DONE;
					end else if (take) begin
						if (group_full) begin
							bits_d = '0;
							held_d = '0;
							done_d = done_q + 4'd1;
							if (done_q == 4'd3) begin
								// skip the center guard: one module plus five
								next_d = next_q + (mw_x << 2) + (mw_x << 1);
							end else begin
								next_d = next_q + mw_x;
							end
							if (done_q == 4'd7) begin
								phase_d = PH_DONE;
							end
						end else begin
							bits_d = bits_shift;
							held_d = held_q + 3'd1;
							next_d = next_q + mw_x;
						end
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
			col_d = CW'(col_inc);
			if (col_inc >= w_eff) begin
				if (phase_d == PH_MEASURE || phase_d == PH_SAMPLE) begin
					phase_d = PH_DONE;
				end
				col_d = '0;
				row_d = RW'(row_inc);
				if (row_inc >= h_eff) begin
					phase_d = PH_SEARCH;
					col_d = '0;
					row_d = '0;
					left_d = '0;
					mw_d = '0;
					next_d = '0;
					bits_d = '0;
					held_d = '0;
					done_d = '0;
				end
			end
		end
	end

	// outputs
	always_comb begin
		push = accept && group_full;
		push_group.bits = bits_shift;
		push_group.position = done_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
			mw_q <= '0;
			next_q <= '0;
			bits_q <= '0;
			held_q <= '0;
			done_q <= '0;
		end else begin
			phase_q <= phase_d;
			col_q <= col_d;
			row_q <= row_d;
			left_q <= left_d;
			mw_q <= mw_d;
			next_q <= next_d;
			bits_q <= bits_d;
			held_q <= held_d;
			done_q <= done_d;
		end
	end

endmodule

`default_nettype wire

### sv/ean8_queue.sv
`default_nettype none

module ean8_queue import ean8_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire group_t push_group,
	input  wire logic   pop,
	output logic        full,
	output logic        empty,
	output group_t      head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	group_t mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count_q;

	assign full = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

### sv/ean8_back.sv
`default_nettype none

module ean8_back import ean8_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   queue_empty,
	input  wire group_t head,
	output logic        pop,
	output logic        result_valid,
	input  wire logic   result_stall,
	output logic [3:0]  digit,
	output logic        matched,
	output logic [2:0]  position,
	output logic        last
);

	logic [4:0] lookup;
	logic valid_q;
	logic [3:0] digit_q;
	logic matched_q;
	logic [2:0] position_q;
	logic last_q;

	assign lookup = match_code(head.bits, head.position[2]);
	assign pop = !queue_empty && (!valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			digit_q <= lookup[3:0];
			matched_q <= lookup[4];
			position_q <= head.position;
			last_q <= (head.position == 3'd7);
		end
	end

	assign result_valid = valid_q;
	assign digit = digit_q;
	assign matched = matched_q;
	assign position = position_q;
	assign last = last_q;

endmodule

`default_nettype wire

### sv/ean8_scanline_decoder.sv
// channel   signals                                       width  dir
// pixel     pixel_valid, pixel_stall, pixel                1      in
// result    result_valid, result_stall, digit, matched,    4,1,   out
//           position, last                                 3,1
// config    cfg_write, cfg_index, cfg_data                 1,1,11 in
//
// One pixel per cycle is taken unless the queue is full; a digit passes the queue, then the output register.
// Throughput is set by the per-pixel counter and compare update in the front stage.
// arst_n clears the scan state and sets both image sizes to 1024.
// A two-entry queue splits front and back: pixels stall only when it is full.
`default_nettype none

module ean8_scanline_decoder import ean8_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             pixel_valid,
	output logic                  pixel_stall,
	input  wire logic             pixel,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic [3:0]            digit,
	output logic                  matched,
	output logic [2:0]            position,
	output logic                  last
);

	logic [CFG_W-1:0] image_width_q, image_height_q;
	logic queue_full, queue_empty, push, pop;
	group_t push_group, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RESET;
			image_height_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ean8_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.image_width(image_width_q),
		.image_height(image_height_q),
		.pixel(pixel),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.queue_full(queue_full),
		.push(push),
		.push_group(push_group)
	);

	ean8_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_group(push_group),
		.pop(pop),
		.full(queue_full),
		.empty(queue_empty),
		.head(head)
	);

	ean8_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.queue_empty(queue_empty),
		.head(head),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.digit(digit),
		.matched(matched),
		.position(position),
		.last(last)
	);

endmodule

`default_nettype wire
